// ----- hw/rtl/dspg_pkg.sv -----
// ----------------------------------------------------------------------------
// dspg_pkg: shared types and constants for the dual stepper pulse generator
// Operation codes, result widths and the microstep pin decode.
// ----------------------------------------------------------------------------
package dspg_pkg;

    localparam int DSPG_DELAY_WIDTH = 12;
    localparam int COUNT_WIDTH      = 16;
    localparam int MODE_WIDTH       = 3;
    localparam int OP_WIDTH         = 2;

    // Modes at or above this value drive all three microstep pins high.
    localparam logic [MODE_WIDTH-1:0] MODE_ALL_HIGH_FROM = 3'd4;

    // Result word: two step pins, two dir pins, two mode fields, enable, two counts.
    localparam int OUT_BITS     = 4 + 2 * MODE_WIDTH + 1 + 2 * COUNT_WIDTH;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [OP_WIDTH-1:0] t_op;

    localparam t_op OP_TICK   = 2'd0;
    localparam t_op OP_SPEED  = 2'd1;
    localparam t_op OP_FETCH  = 2'd2;
    localparam t_op OP_ENABLE = 2'd3;

    typedef struct packed {
        logic                   step;       // step level after the transfer
        logic                   dir;        // 1 forward
        logic [MODE_WIDTH-1:0]  mode;       // MS3 MS2 MS1
        logic [COUNT_WIDTH-1:0] count_out;  // count before clearing, fetch only
        logic [COUNT_WIDTH-1:0] live_count; // count held now
    } t_motor_status;

    function automatic logic [MODE_WIDTH-1:0] mode_to_pins(input logic [MODE_WIDTH-1:0] mode);
        logic [MODE_WIDTH-1:0] pins;
        if (mode < MODE_ALL_HIGH_FROM) begin
            pins = {1'b0, mode[1:0]};
        end else begin
            pins = '1;
        end
        return pins;
    endfunction

endpackage

// ----- hw/rtl/dspg_motor.sv -----
// ----------------------------------------------------------------------------
// dspg_motor: one stepper channel
// Holds the delay, divider, step level, step count, direction and mode pins
// and updates them for each command passed to the result stage.
// ----------------------------------------------------------------------------
module dspg_motor #(
    parameter int DELAY_WIDTH = dspg_pkg::DSPG_DELAY_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  dspg_pkg::t_op               i_op,
    input  logic [DELAY_WIDTH-1:0]      i_delay,
    input  logic                        i_reverse,
    input  logic [dspg_pkg::MODE_WIDTH-1:0] i_microstep,
    output dspg_pkg::t_motor_status     o_status
);
    import dspg_pkg::*;

    logic [DELAY_WIDTH-1:0] r_half, n_half;
    logic [DELAY_WIDTH:0]   r_div, n_div;
    logic                   r_level, n_level;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_rev, n_rev;
    logic [MODE_WIDTH-1:0]  r_mode, n_mode;
    logic [DELAY_WIDTH:0]   div_inc;
    logic [COUNT_WIDTH-1:0] count_out;

    assign div_inc = r_div + 1'b1;

    always_comb begin
        n_half    = r_half;
        n_div     = r_div;
        n_level   = r_level;
        n_count   = r_count;
        n_rev     = r_rev;
        n_mode    = r_mode;
        count_out = '0;
        unique case (i_op)
            OP_TICK: begin
                if (r_half != '0) begin
                    if (div_inc > {1'b0, r_half}) begin
                        n_div   = '0;
                        n_level = ~r_level;
                        // The count moves only on the rising step edge.
                        if (!r_level) begin
                            n_count = r_rev ? (r_count - 1'b1) : (r_count + 1'b1);
                        end
                    end else begin
                        n_div = div_inc;
                    end
                end
            end
            OP_SPEED: begin
                n_half = i_delay;
                n_rev  = i_reverse;
                n_mode = mode_to_pins(i_microstep);
            end
            OP_FETCH: begin
                count_out = r_count;
                n_count   = '0;
            end
            OP_ENABLE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= '0;
            r_div   <= '0;
            r_level <= 1'b0;
            r_count <= '0;
            r_rev   <= 1'b0;
            r_mode  <= '0;
        end else if (i_load) begin
            r_half  <= n_half;
            r_div   <= n_div;
            r_level <= n_level;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_mode  <= n_mode;
        end
    end

    assign o_status.step       = n_level;
    assign o_status.dir        = ~n_rev;
    assign o_status.mode       = n_mode;
    assign o_status.count_out  = count_out;
    assign o_status.live_count = r_count;

endmodule

// ----- hw/rtl/dual_stepper_pulse_generator_unit.sv -----
// ----------------------------------------------------------------------------
// dual_stepper_pulse_generator_unit: two-channel stepper step generator
// Ticks, speed loads, count fetches and enable writes come in as a stream;
// every command yields one result with the pin levels after it.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_*     | in        | tuser: op; tdata: delays, directions, modes, enable
//  m_*     | out       | tdata: pins, enable, counts (one per command)
//
//  A command is registered at the input, then processed and registered into
//  the result stage: one command per cycle sustained while m_tready is high.
//  The result stage advances whenever it is empty or taken.
//  A stall on m_tready holds both stages and s_tready drops once the input
//  register is full. Reset stops both motors and disables the drivers.
// ----------------------------------------------------------------------------
module dual_stepper_pulse_generator_unit #(
    parameter int DELAY_WIDTH = dspg_pkg::DSPG_DELAY_WIDTH,
    localparam int IN_BITS     = 2 * DELAY_WIDTH + 2 * (1 + dspg_pkg::MODE_WIDTH) + 1,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata from bit 0: left_delay, left_reverse, left_microstep, right_delay,
    // right_reverse, right_microstep, enable, zero fill
    input  logic [IN_TDATA_W-1:0]            s_tdata,
    // tuser: op
    input  logic [dspg_pkg::OP_WIDTH-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata from bit 0: left_step_pin, right_step_pin, left_dir_pin,
    // right_dir_pin, left_mode_pins, right_mode_pins, enable_pin_n,
    // left_count_out, right_count_out, zero fill
    output logic [dspg_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import dspg_pkg::*;

    localparam int L_DLY  = 0;
    localparam int L_REV  = L_DLY + DELAY_WIDTH;
    localparam int L_MS   = L_REV + 1;
    localparam int R_DLY  = L_MS + MODE_WIDTH;
    localparam int R_REV  = R_DLY + DELAY_WIDTH;
    localparam int R_MS   = R_REV + 1;
    localparam int EN_BIT = R_MS + MODE_WIDTH;

    logic                 r_in_valid;
    t_op                  r_in_op;
    logic [IN_BITS-1:0]   r_in_data;
    logic                 r_out_valid;
    logic                 r_out_fetch;
    logic [OUT_BITS-1:0]  r_out_data;
    logic                 r_enable_n, n_enable_n;
    logic                 advance;
    logic                 load;
    t_motor_status        left_st, right_st;

    assign advance  = !r_out_valid || m_tready;
    assign load     = r_in_valid && advance;
    assign s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_op   <= s_tuser;
            r_in_data <= s_tdata[IN_BITS-1:0];
        end
    end

    dspg_motor #(.DELAY_WIDTH(DELAY_WIDTH)) u_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_op       (r_in_op),
        .i_delay    (r_in_data[L_REV-1:L_DLY]),
        .i_reverse  (r_in_data[L_REV]),
        .i_microstep(r_in_data[R_DLY-1:L_MS]),
        .o_status   (left_st)
    );

    dspg_motor #(.DELAY_WIDTH(DELAY_WIDTH)) u_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_op       (r_in_op),
        .i_delay    (r_in_data[R_REV-1:R_DLY]),
        .i_reverse  (r_in_data[R_REV]),
        .i_microstep(r_in_data[EN_BIT-1:R_MS]),
        .o_status   (right_st)
    );

    always_comb begin
        n_enable_n = r_enable_n;
        if (r_in_op == OP_ENABLE) begin
            n_enable_n = ~r_in_data[EN_BIT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_n  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_enable_n <= n_enable_n;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_fetch <= (r_in_op == OP_FETCH);
            r_out_data  <= {right_st.count_out, left_st.count_out, n_enable_n,
                            right_st.mode, left_st.mode, right_st.dir, left_st.dir,
                            right_st.step, left_st.step};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, r_out_data};

    // Counts are reported only for a fetch.
    a_count_only_on_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_fetch) |-> (r_out_data[OUT_BITS-1:OUT_BITS-2*COUNT_WIDTH] == '0))
        else $error("nonzero count in a result that is not a fetch");

    // A fetch leaves both counts cleared.
    a_fetch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in_op == OP_FETCH) |=>
            (left_st.live_count == '0 && right_st.live_count == '0))
        else $error("step count not cleared by fetch");

    // Mode pins are either a direct mode with MS3 low or all high.
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data[6] == 1'b0 || r_out_data[6:4] == 3'b111) &&
                         (r_out_data[9] == 1'b0 || r_out_data[9:7] == 3'b111)))
        else $error("illegal microstep pin pattern");

endmodule

// ----- verif/dual_stepper_pulse_generator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_stepper_pulse_generator_unit_tb: self-checking bench for the step unit
// A queue-fed driver streams ticks, speed loads, count fetches and enable
// writes into the unit. A per-command motor predictor computes the pin word
// for every accepted command, and a monitor compares each result transfer,
// field by field, with the oldest prediction. Both sides throttle at random.
// ----------------------------------------------------------------------------
module dual_stepper_pulse_generator_unit_tb;
    import dspg_pkg::*;

    localparam int DW          = DSPG_DELAY_WIDTH;
    localparam int IN_W        = ((2 * DW + 2 * (1 + MODE_WIDTH) + 1 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int LONG_STALL  = 400;
    localparam int PHASE_ITEMS = 570;
    // A short run at a delay of one after a fetch: the left count climbs and
    // the reversed right count drops below zero.
    localparam int WRAP_TICKS  = 40;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        t_op                   op;
        logic [DW-1:0]         ldly;
        logic                  lrev;
        logic [MODE_WIDTH-1:0] lms;
        logic [DW-1:0]         rdly;
        logic                  rrev;
        logic [MODE_WIDTH-1:0] rms;
        logic                  en;
    } t_cmd;

    typedef struct packed {
        logic                   step_l;
        logic                   step_r;
        logic                   dir_l;
        logic                   dir_r;
        logic [MODE_WIDTH-1:0]  mode_l;
        logic [MODE_WIDTH-1:0]  mode_r;
        logic                   en_n;
        logic [COUNT_WIDTH-1:0] cnt_l;
        logic [COUNT_WIDTH-1:0] cnt_r;
    } t_pins;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata  = '0;
    logic [OP_WIDTH-1:0]    s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Motor state mirrored by the predictor.
    logic [DW-1:0]          half_period [2];
    logic [DW:0]            divider     [2];
    logic                   step_lvl    [2];
    logic [COUNT_WIDTH-1:0] steps       [2];
    logic                   rev         [2];
    logic [MODE_WIDTH-1:0]  ms_state    [2];
    logic                   en_n_state;

    t_cmd  pending_cmds  [$];
    t_pins expected_pins [$];

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    mismatches    = 0;
    int    results_seen  = 0;
    int    cycles        = 0;
    int    stall_left    = 0;
    logic  stall_arm     = 1'b0;

    dual_stepper_pulse_generator_unit #(
        .DELAY_WIDTH(DW)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [MODE_WIDTH-1:0] ms_pins(input logic [MODE_WIDTH-1:0] ms);
        return (ms >= MODE_ALL_HIGH_FROM) ? '1 : {1'b0, ms[1:0]};
    endfunction

    // Advances the motor state by one command and returns the pin word after it.
    function automatic t_pins apply_command(input t_cmd c);
        t_pins p;
        p.cnt_l = '0;
        p.cnt_r = '0;
        case (c.op)
            OP_TICK: begin
                for (int m = 0; m < 2; m++) begin
                    if (half_period[m] != '0) begin
                        divider[m] = divider[m] + 1'b1;
                        if (divider[m] > half_period[m]) begin
                            divider[m]  = '0;
                            step_lvl[m] = ~step_lvl[m];
                            if (step_lvl[m]) begin
                                steps[m] = rev[m] ? steps[m] - 1'b1 : steps[m] + 1'b1;
                            end
                        end
                    end
                end
            end
            OP_SPEED: begin
                half_period[0] = c.ldly;
                rev[0]         = c.lrev;
                ms_state[0]    = ms_pins(c.lms);
                half_period[1] = c.rdly;
                rev[1]         = c.rrev;
                ms_state[1]    = ms_pins(c.rms);
            end
            OP_FETCH: begin
                p.cnt_l  = steps[0];
                p.cnt_r  = steps[1];
                steps[0] = '0;
                steps[1] = '0;
            end
            default: begin
                en_n_state = ~c.en;
            end
        endcase
        p.step_l = step_lvl[0];
        p.step_r = step_lvl[1];
        p.dir_l  = ~rev[0];
        p.dir_r  = ~rev[1];
        p.mode_l = ms_state[0];
        p.mode_r = ms_state[1];
        p.en_n   = en_n_state;
        return p;
    endfunction

    function automatic t_cmd mk(input t_op op, input int ldly, input bit lrev, input int lms,
                                input int rdly, input bit rrev, input int rms, input bit en);
        t_cmd c;
        c.op   = op;
        c.ldly = DW'(ldly);
        c.lrev = lrev;
        c.lms  = MODE_WIDTH'(lms);
        c.rdly = DW'(rdly);
        c.rrev = rrev;
        c.rms  = MODE_WIDTH'(rms);
        c.en   = en;
        return c;
    endfunction

    // Mostly short delays so that the motors actually step between loads.
    function automatic logic [DW-1:0] pick_delay();
        logic [DW-1:0] d;
        case ($urandom_range(9))
            0:       d = '0;
            7, 8:    d = DW'($urandom_range(7, 40));
            9:       d = DW'($urandom);
            default: d = DW'($urandom_range(1, 6));
        endcase
        return d;
    endfunction

    function automatic t_cmd rand_command();
        t_cmd c;
        int   r;
        r      = $urandom_range(99);
        c.ldly = DW'($urandom);
        c.lrev = 1'($urandom);
        c.lms  = MODE_WIDTH'($urandom);
        c.rdly = DW'($urandom);
        c.rrev = 1'($urandom);
        c.rms  = MODE_WIDTH'($urandom);
        c.en   = 1'($urandom);
        if (r < 60) begin
            c.op = OP_TICK;
        end else if (r < 75) begin
            c.op   = OP_SPEED;
            c.ldly = pick_delay();
            c.rdly = pick_delay();
        end else if (r < 88) begin
            c.op = OP_FETCH;
        end else begin
            c.op = OP_ENABLE;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatches < PRINT_CAP) begin
            $display("result %0d: %s is %0d, predicted %0d", results_seen, field, got, want);
        end
        mismatches++;
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] d);
        t_pins want;
        t_pins got;
        got.step_l = d[0];
        got.step_r = d[1];
        got.dir_l  = d[2];
        got.dir_r  = d[3];
        got.mode_l = d[6:4];
        got.mode_r = d[9:7];
        got.en_n   = d[10];
        got.cnt_l  = d[26:11];
        got.cnt_r  = d[42:27];
        if (expected_pins.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
        end else begin
            want = expected_pins.pop_front();
            if (got.step_l != want.step_l) begin
                report_mismatch("left_step_pin", int'(got.step_l), int'(want.step_l));
            end
            if (got.step_r != want.step_r) begin
                report_mismatch("right_step_pin", int'(got.step_r), int'(want.step_r));
            end
            if (got.dir_l != want.dir_l) begin
                report_mismatch("left_dir_pin", int'(got.dir_l), int'(want.dir_l));
            end
            if (got.dir_r != want.dir_r) begin
                report_mismatch("right_dir_pin", int'(got.dir_r), int'(want.dir_r));
            end
            if (got.mode_l != want.mode_l) begin
                report_mismatch("left_mode_pins", int'(got.mode_l), int'(want.mode_l));
            end
            if (got.mode_r != want.mode_r) begin
                report_mismatch("right_mode_pins", int'(got.mode_r), int'(want.mode_r));
            end
            if (got.en_n != want.en_n) begin
                report_mismatch("enable_pin_n", int'(got.en_n), int'(want.en_n));
            end
            if (got.cnt_l != want.cnt_l) begin
                report_mismatch("left_count_out", int'($signed(got.cnt_l)),
                                int'($signed(want.cnt_l)));
            end
            if (got.cnt_r != want.cnt_r) begin
                report_mismatch("right_count_out", int'($signed(got.cnt_r)),
                                int'($signed(want.cnt_r)));
            end
        end
        results_seen++;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_pins.size() != 0) @(posedge i_clk);
    endtask

    // Command driver: a transfer is predicted at the edge where it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_pins.push_back(apply_command(pending_cmds.pop_front()));
            end
            if (pending_cmds.size() == 0 || $urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_cmds[0].op;
                s_tdata  <= IN_W'({pending_cmds[0].en,
                                   pending_cmds[0].rms, pending_cmds[0].rrev,
                                   pending_cmds[0].rdly,
                                   pending_cmds[0].lms, pending_cmds[0].lrev,
                                   pending_cmds[0].ldly});
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
            end
            m_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, started by a one-cycle arm pulse.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
        end else if (stall_arm) begin
            stall_left <= LONG_STALL;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("dual_stepper_pulse_generator_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin
        for (int m = 0; m < 2; m++) begin
            half_period[m] = '0;
            divider[m]     = '0;
            step_lvl[m]    = 1'b0;
            steps[m]       = '0;
            rev[m]         = 1'b0;
            ms_state[m]    = '0;
        end
        en_n_state = 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 80;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state, enable both ways, unused fields set, extreme
        // delays and modes, a delay lowered below the running divider, and a
        // reverse count that wraps below zero.
        pending_cmds.push_back(mk(OP_FETCH, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_ENABLE, 0, 0, 0, 0, 0, 0, 1));
        pending_cmds.push_back(mk(OP_ENABLE, 4095, 1, 7, 4095, 1, 7, 0));
        pending_cmds.push_back(mk(OP_TICK, 4095, 1, 7, 4095, 1, 7, 1));
        pending_cmds.push_back(mk(OP_SPEED, 1, 0, 0, 4095, 1, 7, 1));
        repeat (8) pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_FETCH, 4095, 1, 7, 4095, 1, 7, 1));
        pending_cmds.push_back(mk(OP_SPEED, 4095, 0, 3, 1, 1, 4, 0));
        repeat (6) pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_SPEED, 2, 0, 5, 0, 0, 6, 0));
        repeat (2) pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_FETCH, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_ENABLE, 0, 0, 0, 0, 0, 0, 1));

        repeat (PHASE_ITEMS) pending_cmds.push_back(rand_command());
        wait_drained();

        // The receiver holds off while the sender keeps offering, so the
        // unit fills up and deasserts s_tready.
        send_idle_pct = 80;
        recv_idle_pct = 38;
        repeat (PHASE_ITEMS) pending_cmds.push_back(rand_command());
        @(posedge i_clk);
        stall_arm <= 1'b1;
        @(posedge i_clk);
        stall_arm <= 1'b0;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (PHASE_ITEMS) pending_cmds.push_back(rand_command());
        pending_cmds.push_back(mk(OP_SPEED, 1, 0, 2, 1, 1, 1, 0));
        pending_cmds.push_back(mk(OP_FETCH, 0, 0, 0, 0, 0, 0, 0));
        repeat (WRAP_TICKS) pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_FETCH, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("dual_stepper_pulse_generator_unit_tb: done, clean");
        end else begin
            $display("dual_stepper_pulse_generator_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dspg_pkg.sv
hw/rtl/dspg_motor.sv
hw/rtl/dual_stepper_pulse_generator_unit.sv
verif/dual_stepper_pulse_generator_unit_tb.sv
